FILE: hdl/cmsc_pkg.sv
// Shared types and constants for the carrier status message checker.
package cmsc_pkg;

   localparam int VAL_W = 16;
   localparam int STATUS_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;

   // Words skipped after the carrier number and inside each branch record
   localparam logic [1:0] HDR_SKIP = 2'd3;
   localparam logic [1:0] BRANCH_SKIP = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 4'd0,
      ST_CRR_CNT  = 4'd1,
      ST_CRR_NO   = 4'd2,
      ST_BRC_CNT  = 4'd3,
      ST_BRC_NO   = 4'd4,
      ST_ALM_CNT  = 4'd5,
      ST_ALM_CODE = 4'd6,
      ST_CRD_CNT  = 4'd7,
      ST_SLOT     = 4'd8
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_CRR_NO   = 4'd1,
      PH_HDR_SKIP = 4'd2,
      PH_BRC_CNT  = 4'd3,
      PH_BRC_NO   = 4'd4,
      PH_BRC_SKIP = 4'd5,
      PH_ALM_CNT  = 4'd6,
      PH_ALM_CODE = 4'd7,
      PH_CRD_CNT  = 4'd8,
      PH_SLOT     = 4'd9
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CARRIER_MAX       = 3'd0,
      REG_BRANCH_COUNT_MAX  = 3'd1,
      REG_BRANCH_NUMBER_MAX = 3'd2,
      REG_ALARM_COUNT_MAX   = 3'd3,
      REG_ALARM_CODE_MIN    = 3'd4,
      REG_ALARM_CODE_MAX    = 3'd5,
      REG_CARD_COUNT_MAX    = 3'd6,
      REG_SLOT_MAX          = 3'd7
   } cfg_index_type;

   typedef struct packed {
      logic [3:0] carrier_max;
      logic [3:0] branch_count_max;
      logic [3:0] branch_number_max;
      logic [7:0] alarm_count_max;
      logic [7:0] alarm_code_min;
      logic [7:0] alarm_code_max;
      logic [3:0] card_count_max;
      logic [5:0] slot_max;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [VAL_W-1:0] bad_value;
   } res_type;

endpackage

FILE: hdl/cmsc_if.sv
// Handshake channel interfaces for message words and check results.
interface cmsc_req_if #(parameter int WORD_WIDTH = 16) ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] msg_word;
   logic                  first_word;

   modport source (output valid, output msg_word, output first_word, input ready);
   modport sink (input valid, input msg_word, input first_word, output ready);
endinterface

interface cmsc_rsp_if ();
   logic                           valid;
   logic                           ready;
   logic [cmsc_pkg::STATUS_W-1:0]  status;
   logic [cmsc_pkg::VAL_W-1:0]     bad_value;

   modport source (output valid, output status, output bad_value, input ready);
   modport sink (input valid, input status, input bad_value, output ready);
endinterface

FILE: hdl/cmsc_cfg_regs.sv
// Limit registers written through the plain write port.
module cmsc_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cmsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output cmsc_pkg::cfg_type                cfg
);

   cmsc_pkg::cfg_type cfg_ff;
   cmsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cmsc_pkg::cfg_index_type'(csr_index))
            cmsc_pkg::REG_CARRIER_MAX:       cfg_in.carrier_max = csr_wdata[3:0];
            cmsc_pkg::REG_BRANCH_COUNT_MAX:  cfg_in.branch_count_max = csr_wdata[3:0];
            cmsc_pkg::REG_BRANCH_NUMBER_MAX: cfg_in.branch_number_max = csr_wdata[3:0];
            cmsc_pkg::REG_ALARM_COUNT_MAX:   cfg_in.alarm_count_max = csr_wdata[7:0];
            cmsc_pkg::REG_ALARM_CODE_MIN:    cfg_in.alarm_code_min = csr_wdata[7:0];
            cmsc_pkg::REG_ALARM_CODE_MAX:    cfg_in.alarm_code_max = csr_wdata[7:0];
            cmsc_pkg::REG_CARD_COUNT_MAX:    cfg_in.card_count_max = csr_wdata[3:0];
            cmsc_pkg::REG_SLOT_MAX:          cfg_in.slot_max = csr_wdata[5:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_max       <= 4'd5;
         cfg_ff.branch_count_max  <= 4'd8;
         cfg_ff.branch_number_max <= 4'd7;
         cfg_ff.alarm_count_max   <= 8'd255;
         cfg_ff.alarm_code_min    <= 8'd221;
         cfg_ff.alarm_code_max    <= 8'd255;
         cfg_ff.card_count_max    <= 4'd6;
         cfg_ff.slot_max          <= 6'd56;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/cmsc_parser.sv
// Message layout state machine with per-field range checks.
module cmsc_parser #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [WORD_WIDTH-1:0] word,
   input  logic                  first,
   input  cmsc_pkg::cfg_type     cfg,
   output cmsc_pkg::res_type     res,
   output cmsc_pkg::phase_type   phase
);

   localparam int VW = cmsc_pkg::VAL_W;

   cmsc_pkg::phase_type phase_ff, phase_in;
   logic [3:0] carriers_left_ff, carriers_left_in;
   logic [3:0] branches_left_ff, branches_left_in;
   logic [7:0] entries_left_ff, entries_left_in;
   logic [1:0] skip_left_ff, skip_left_in;

   logic [WORD_WIDTH-1:0] crr_lim, brc_cnt_lim, brc_no_lim, alm_cnt_lim;
   logic [WORD_WIDTH-1:0] code_lo, code_hi, crd_lim, slot_lim, one_w;
   logic [VW-1:0]         w_val;
   logic [3:0]            crr_dec, brc_dec;
   logic [7:0]            ent_dec;
   logic [1:0]            skip_dec;
   logic                  w_zero;

   assign crr_lim     = WORD_WIDTH'(cfg.carrier_max);
   assign brc_cnt_lim = WORD_WIDTH'(cfg.branch_count_max);
   assign brc_no_lim  = WORD_WIDTH'(cfg.branch_number_max);
   assign alm_cnt_lim = WORD_WIDTH'(cfg.alarm_count_max);
   assign code_lo     = WORD_WIDTH'(cfg.alarm_code_min);
   assign code_hi     = WORD_WIDTH'(cfg.alarm_code_max);
   assign crd_lim     = WORD_WIDTH'(cfg.card_count_max);
   assign slot_lim    = WORD_WIDTH'(cfg.slot_max);
   assign one_w       = WORD_WIDTH'(1);
   assign w_val       = VW'(word);
   assign w_zero      = (word == '0);

   assign crr_dec  = carriers_left_ff - 4'd1;
   assign brc_dec  = branches_left_ff - 4'd1;
   assign ent_dec  = entries_left_ff - 8'd1;
   assign skip_dec = skip_left_ff - 2'd1;

   always_comb begin
      phase_in         = phase_ff;
      carriers_left_in = carriers_left_ff;
      branches_left_in = branches_left_ff;
      entries_left_in  = entries_left_ff;
      skip_left_in     = skip_left_ff;
      res.valid        = 1'b0;
      res.status       = cmsc_pkg::ST_OK;
      res.bad_value    = '0;
      if (fire) begin
         if (first) begin
            // A first flag always restarts, dropping any message in progress
            if (word > crr_lim) begin
               res = '{valid: 1'b1, status: cmsc_pkg::ST_CRR_CNT, bad_value: w_val};
               phase_in = cmsc_pkg::PH_IDLE;
            end else if (w_zero) begin
               res.valid = 1'b1;
               phase_in  = cmsc_pkg::PH_IDLE;
            end else begin
               carriers_left_in = word[3:0];
               phase_in = cmsc_pkg::PH_CRR_NO;
            end
         end else begin
            unique case (phase_ff)
               cmsc_pkg::PH_IDLE: begin
               end
               cmsc_pkg::PH_CRR_NO: begin
                  if (word < one_w || word > crr_lim) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_CRR_NO, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else begin
                     skip_left_in = cmsc_pkg::HDR_SKIP;
                     phase_in = cmsc_pkg::PH_HDR_SKIP;
                  end
               end
               cmsc_pkg::PH_HDR_SKIP: begin
                  skip_left_in = skip_dec;
                  if (skip_dec == 2'd0) begin
                     phase_in = cmsc_pkg::PH_BRC_CNT;
                  end
               end
               cmsc_pkg::PH_BRC_CNT: begin
                  if (word > brc_cnt_lim) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_BRC_CNT, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else begin
                     branches_left_in = word[3:0];
                     phase_in = w_zero ? cmsc_pkg::PH_ALM_CNT : cmsc_pkg::PH_BRC_NO;
                  end
               end
               cmsc_pkg::PH_BRC_NO: begin
                  if (word > brc_no_lim) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_BRC_NO, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else begin
                     skip_left_in = cmsc_pkg::BRANCH_SKIP;
                     phase_in = cmsc_pkg::PH_BRC_SKIP;
                  end
               end
               cmsc_pkg::PH_BRC_SKIP: begin
                  skip_left_in = skip_dec;
                  if (skip_dec == 2'd0) begin
                     branches_left_in = brc_dec;
                     phase_in = (brc_dec == 4'd0) ? cmsc_pkg::PH_ALM_CNT
                                                  : cmsc_pkg::PH_BRC_NO;
                  end
               end
               cmsc_pkg::PH_ALM_CNT: begin
                  if (word > alm_cnt_lim) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_ALM_CNT, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else begin
                     entries_left_in = word[7:0];
                     phase_in = w_zero ? cmsc_pkg::PH_CRD_CNT : cmsc_pkg::PH_ALM_CODE;
                  end
               end
               cmsc_pkg::PH_ALM_CODE: begin
                  if (word < code_lo || word > code_hi) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_ALM_CODE, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else begin
                     entries_left_in = ent_dec;
                     if (ent_dec == 8'd0) begin
                        phase_in = cmsc_pkg::PH_CRD_CNT;
                     end
                  end
               end
               cmsc_pkg::PH_CRD_CNT: begin
                  if (word > crd_lim) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_CRD_CNT, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else if (w_zero) begin
                     // Carrier finished: next carrier or message OK
                     carriers_left_in = crr_dec;
                     if (crr_dec == 4'd0) begin
                        res.valid = 1'b1;
                        phase_in  = cmsc_pkg::PH_IDLE;
                     end else begin
                        phase_in = cmsc_pkg::PH_CRR_NO;
                     end
                  end else begin
                     entries_left_in = 8'(word[3:0]);
                     phase_in = cmsc_pkg::PH_SLOT;
                  end
               end
               cmsc_pkg::PH_SLOT: begin
                  if (word < one_w || word > slot_lim) begin
                     res = '{valid: 1'b1, status: cmsc_pkg::ST_SLOT, bad_value: w_val};
                     phase_in = cmsc_pkg::PH_IDLE;
                  end else begin
                     entries_left_in = ent_dec;
                     if (ent_dec == 8'd0) begin
                        carriers_left_in = crr_dec;
                        if (crr_dec == 4'd0) begin
                           res.valid = 1'b1;
                           phase_in  = cmsc_pkg::PH_IDLE;
                        end else begin
                           phase_in = cmsc_pkg::PH_CRR_NO;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = cmsc_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= cmsc_pkg::PH_IDLE;
         carriers_left_ff <= '0;
         branches_left_ff <= '0;
         entries_left_ff  <= '0;
         skip_left_ff     <= '0;
      end else begin
         phase_ff         <= phase_in;
         carriers_left_ff <= carriers_left_in;
         branches_left_ff <= branches_left_in;
         entries_left_ff  <= entries_left_in;
         skip_left_ff     <= skip_left_in;
      end
   end

   assign phase = phase_ff;

endmodule

FILE: hdl/cmsc_rsp_reg.sv
// Result register driving the response channel.
module cmsc_rsp_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmsc_pkg::res_type          res,
   output logic                       room,
   cmsc_rsp_if.source                 rsp_ch
);

   logic                           valid_ff, valid_in;
   cmsc_pkg::status_type           status_ff;
   logic [cmsc_pkg::VAL_W-1:0]     bad_value_ff;

   assign room = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only on push; holds while stalled
   always_ff @(posedge clock) begin
      if (push) begin
         status_ff    <= res.status;
         bad_value_ff <= res.bad_value;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.bad_value = bad_value_ff;

endmodule

FILE: hdl/carrier_status_msg_checker.sv
// Top level of the carrier status report message checker.
// A word's result, if any, passes the input register and then the result register before it is valid.
// Throughput: one word per cycle while results are taken; the input register refills while a result waits.
// A stalled result blocks only once the input register also holds an unprocessed word.
// Reset (synchronous): parser goes idle, counters clear, limits take default values.
module carrier_status_msg_checker #(
   parameter int WORD_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   cmsc_req_if.sink                         req_ch,
   cmsc_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [cmsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   cmsc_pkg::cfg_type     cfg;
   cmsc_pkg::res_type     res;
   cmsc_pkg::phase_type   phase;

   // Input register: one word waiting for the parser
   logic                  in_valid_ff, in_valid_in;
   logic [WORD_WIDTH-1:0] in_word_ff;
   logic                  in_first_ff;

   logic                  room;
   logic                  advance;
   logic                  accept;

   // Parse the held word once the result register can take whatever it yields
   assign advance = in_valid_ff && room;
   // Take a new word when the input register is empty or emptying this cycle
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff  <= req_ch.msg_word;
         in_first_ff <= req_ch.first_word;
      end
   end

   cmsc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Layout walk and range checks; emits at most one result per word
   cmsc_parser #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .word  (in_word_ff),
      .first (in_first_ff),
      .cfg   (cfg),
      .res   (res),
      .phase (phase)
   );

   cmsc_rsp_reg u_rsp (
      .clock  (clock),
      .reset  (reset),
      .push   (res.valid),
      .res    (res),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   // Any result ends the message: parser must be idle afterwards
   a_result_ends_msg: assert property (@(posedge clock) disable iff (reset)
      res.valid |=> phase == cmsc_pkg::PH_IDLE)
      else $error("parser not idle after a result");

   // Words without the first flag while idle produce nothing
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      advance && !in_first_ff && phase == cmsc_pkg::PH_IDLE |-> !res.valid)
      else $error("result from a word outside a message");

   // OK results carry a zero value
   a_ok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == cmsc_pkg::ST_OK |-> rsp_ch.bad_value == '0)
      else $error("OK result with nonzero value");

   // A result is only produced when the result register has room
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> room && in_valid_ff)
      else $error("result produced without room");

endmodule

FILE: tb/carrier_status_msg_checker_tb.sv
// Self-checking testbench for the carrier status report message checker.
module carrier_status_msg_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cmsc_pkg::*;

   localparam int WORD_W = 16;

   // One message word as the sender offers it
   typedef struct packed {
      logic              first;
      logic [WORD_W-1:0] word;
   } word_item_t;

   // One verdict the checker owes us: error code plus the offending word
   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] bad_value;
   } verdict_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cmsc_req_if #(.WORD_WIDTH(WORD_W)) req_ch ();
   cmsc_rsp_if rsp_ch ();

   carrier_status_msg_checker #(.WORD_WIDTH(WORD_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the limit registers, starting from their reset values
   cfg_type lim = '{carrier_max: 4'd5, branch_count_max: 4'd8, branch_number_max: 4'd7,
                    alarm_count_max: 8'd255, alarm_code_min: 8'd221, alarm_code_max: 8'd255,
                    card_count_max: 4'd6, slot_max: 6'd56};

   // Parser state mirrored from the block
   phase_type parse_phase = PH_IDLE;
   logic [3:0] carriers_left = '0;
   logic [3:0] branches_left = '0;
   logic [7:0] entries_left = '0;
   logic [1:0] skip_left = '0;

   word_item_t word_q[$];        // words waiting to be offered
   word_item_t msg_buf[$];       // message under construction
   verdict_t verdict_q[$];       // verdicts owed by the block, oldest first

   int cut_at;                   // position of the first out-of-range word in msg_buf
   int unsigned bad_pct = 2;     // chance in percent that a checked field is out of range
   int unsigned tx_gap = 0;
   int unsigned rx_gap = 0;
   logic tx_idle_on;
   logic rx_stall_on;
   logic rsp_hold;

   int unsigned words_queued = 0;
   int unsigned words_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned code_hits[9];

   // ---------------------------------------------------------------------
   // Clock and time limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bail out if the run hangs; allows several times the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout after %0d words accepted, %0d results pending",
               words_accepted, verdict_q.size());
      $display("carrier_status_msg_checker_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Mismatch reporting: print one line (first few only) and count
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 30)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Verdict predictor: walks the message layout word by word
   // ---------------------------------------------------------------------
   // Owe a verdict and drop back to idle; later words wait for a first flag
   task automatic post_verdict(status_type code, logic [VAL_W-1:0] value);
      verdict_q.push_back('{status: code, bad_value: value});
      parse_phase = PH_IDLE;
   endtask

   // A carrier's records are done: move to the next carrier or close with OK
   task automatic close_carrier();
      carriers_left = carriers_left - 4'd1;
      if (carriers_left == 4'd0)
         post_verdict(ST_OK, '0);
      else
         parse_phase = PH_CRR_NO;
   endtask

   task automatic advance_parser(logic [WORD_W-1:0] w, logic first);
      // A first flag always restarts, dropping any message in progress
      if (first) begin
         if (w > lim.carrier_max)
            post_verdict(ST_CRR_CNT, w);
         else if (w == '0)
            post_verdict(ST_OK, '0);
         else begin
            carriers_left = w[3:0];
            parse_phase = PH_CRR_NO;
         end
      end else begin
         case (parse_phase)
            PH_CRR_NO: begin
               if (w < 1 || w > lim.carrier_max)
                  post_verdict(ST_CRR_NO, w);
               else begin
                  skip_left = HDR_SKIP;
                  parse_phase = PH_HDR_SKIP;
               end
            end
            PH_HDR_SKIP: begin
               // Two skipped words and the state word are never checked
               skip_left = skip_left - 2'd1;
               if (skip_left == 2'd0)
                  parse_phase = PH_BRC_CNT;
            end
            PH_BRC_CNT: begin
               if (w > lim.branch_count_max)
                  post_verdict(ST_BRC_CNT, w);
               else begin
                  branches_left = w[3:0];
                  parse_phase = (w == '0) ? PH_ALM_CNT : PH_BRC_NO;
               end
            end
            PH_BRC_NO: begin
               if (w > lim.branch_number_max)
                  post_verdict(ST_BRC_NO, w);
               else begin
                  skip_left = BRANCH_SKIP;
                  parse_phase = PH_BRC_SKIP;
               end
            end
            PH_BRC_SKIP: begin
               skip_left = skip_left - 2'd1;
               if (skip_left == 2'd0) begin
                  branches_left = branches_left - 4'd1;
                  parse_phase = (branches_left == 4'd0) ? PH_ALM_CNT : PH_BRC_NO;
               end
            end
            PH_ALM_CNT: begin
               if (w > lim.alarm_count_max)
                  post_verdict(ST_ALM_CNT, w);
               else begin
                  entries_left = w[7:0];
                  parse_phase = (w == '0) ? PH_CRD_CNT : PH_ALM_CODE;
               end
            end
            PH_ALM_CODE: begin
               // An inverted code window rejects every code
               if (w < lim.alarm_code_min || w > lim.alarm_code_max)
                  post_verdict(ST_ALM_CODE, w);
               else begin
                  entries_left = entries_left - 8'd1;
                  if (entries_left == 8'd0)
                     parse_phase = PH_CRD_CNT;
               end
            end
            PH_CRD_CNT: begin
               if (w > lim.card_count_max)
                  post_verdict(ST_CRD_CNT, w);
               else if (w == '0)
                  close_carrier();
               else begin
                  entries_left = w[7:0];
                  parse_phase = PH_SLOT;
               end
            end
            PH_SLOT: begin
               if (w < 1 || w > lim.slot_max)
                  post_verdict(ST_SLOT, w);
               else begin
                  entries_left = entries_left - 8'd1;
                  if (entries_left == 8'd0)
                     close_carrier();
               end
            end
            default: begin
               // Idle: a word without a first flag is ignored
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Draw a checked field. Out of range with chance bad_pct; otherwise near the
   // low end, or anywhere up to the top (half the time exactly the top) when wide.
   function automatic logic [WORD_W-1:0] field_value(int unsigned lo, int unsigned hi,
                                                     bit wide);
      int unsigned top;
      if ($urandom_range(99, 0) < bad_pct) begin
         if (lo > 0 && $urandom_range(1, 0) == 1)
            return WORD_W'(lo - 1);
         case ($urandom_range(2, 0))
            0: return WORD_W'(hi + 1);
            1: return WORD_W'($urandom_range(65535, hi + 1));
            default: return '1;
         endcase
      end
      if (lo > hi)
         return WORD_W'($urandom_range(255, 0));
      if (wide && $urandom_range(1, 0) == 1)
         return WORD_W'(hi);
      top = (wide || hi - lo <= 2) ? hi : lo + 2;
      return WORD_W'($urandom_range(top, lo));
   endfunction

   // Append a checked field; hand back a usable count even when it is bad
   task automatic push_field(int unsigned lo, int unsigned hi, bit wide,
                             output int unsigned v);
      logic [WORD_W-1:0] w;
      w = field_value(lo, hi, wide);
      if ((w < lo || w > hi) && cut_at < 0)
         cut_at = msg_buf.size();
      msg_buf.push_back('{first: 1'b0, word: w});
      v = (w < lo || w > hi) ? lo : w;
   endtask

   // Append an unchecked word with fully random bits
   task automatic push_raw();
      msg_buf.push_back('{first: 1'b0, word: WORD_W'($urandom)});
   endtask

   task automatic queue_word(logic first, logic [WORD_W-1:0] w);
      word_q.push_back('{first: first, word: w});
      words_queued++;
   endtask

   // Build one message against the current limits: mostly well formed, with
   // the odd bad field, truncation or trailing noise
   task automatic queue_message();
      int unsigned stretch, n_carr, n_brc, n_alm, n_crd, tmp, c;
      msg_buf.delete();
      cut_at = -1;
      // Pick at most one section to run up to its limit; keep the rest short
      stretch = $urandom_range(19, 0);
      push_field(0, lim.carrier_max, stretch == 0, n_carr);
      msg_buf[0].first = 1'b1;
      c = 0;
      while (c < n_carr && cut_at < 0) begin
         push_field(1, lim.carrier_max, 1'b1, tmp);
         repeat (3) push_raw();
         push_field(0, lim.branch_count_max, stretch == 1, n_brc);
         repeat (n_brc) begin
            push_field(0, lim.branch_number_max, 1'b1, tmp);
            repeat (3) push_raw();
         end
         push_field(0, lim.alarm_count_max, stretch == 2, n_alm);
         repeat (n_alm) push_field(lim.alarm_code_min, lim.alarm_code_max, 1'b1, tmp);
         push_field(0, lim.card_count_max, stretch == 3, n_crd);
         repeat (n_crd) push_field(1, lim.slot_max, 1'b1, tmp);
         c++;
      end
      if (cut_at >= 0) begin
         // Keep the bad word and tack on a few words that must be ignored
         while (msg_buf.size() > cut_at + 1)
            void'(msg_buf.pop_back());
         repeat ($urandom_range(3, 0)) push_raw();
      end else if (msg_buf.size() > 1 && $urandom_range(99, 0) < 8) begin
         // Cut the message short; the next first flag drops it silently
         tmp = $urandom_range(msg_buf.size() - 1, 1);
         while (msg_buf.size() > tmp)
            void'(msg_buf.pop_back());
      end else if ($urandom_range(99, 0) < 5) begin
         repeat ($urandom_range(2, 1)) push_raw();
      end
      foreach (msg_buf[i])
         queue_word(msg_buf[i].first, msg_buf[i].word);
   endtask

   task automatic random_phase(int unsigned budget);
      int unsigned start;
      start = words_queued;
      while (words_queued - start < budget)
         queue_message();
   endtask

   // Wait until every word is taken and every verdict is in, then let the
   // pipeline empty out for words that owe nothing
   task automatic wait_idle();
      int unsigned n;
      @(negedge clock);
      while (word_q.size() != 0 || req_ch.valid)
         @(negedge clock);
      n = 0;
      while (verdict_q.size() != 0 && n < 5000) begin
         @(negedge clock);
         n++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Write one limit register and track it in the shadow copy
   task automatic set_limit(cfg_index_type idx, int unsigned v);
      case (idx)
         REG_CARRIER_MAX:       lim.carrier_max = v[3:0];
         REG_BRANCH_COUNT_MAX:  lim.branch_count_max = v[3:0];
         REG_BRANCH_NUMBER_MAX: lim.branch_number_max = v[3:0];
         REG_ALARM_COUNT_MAX:   lim.alarm_count_max = v[7:0];
         REG_ALARM_CODE_MIN:    lim.alarm_code_min = v[7:0];
         REG_ALARM_CODE_MAX:    lim.alarm_code_max = v[7:0];
         REG_CARD_COUNT_MAX:    lim.card_count_max = v[3:0];
         REG_SLOT_MAX:          lim.slot_max = v[5:0];
         default: begin
         end
      endcase
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[7:0];
      @(posedge clock);
   endtask

   // Load a full set of limits: top extremes, bottom extremes, an inverted
   // alarm code window, or random values
   task automatic configure(int unsigned setting);
      int unsigned code_lo, code_hi;
      case (setting)
         1: begin
            code_lo = 0;
            code_hi = 255;
         end
         2: begin
            code_lo = 0;
            code_hi = 0;
         end
         3: begin
            code_lo = $urandom_range(255, 1);
            code_hi = $urandom_range(code_lo - 1, 0);
         end
         default: begin
            code_lo = $urandom_range(255, 0);
            code_hi = ($urandom_range(3, 0) != 0) ? $urandom_range(255, code_lo)
                                                  : $urandom_range(255, 0);
         end
      endcase
      if (setting == 1) begin
         set_limit(REG_CARRIER_MAX, 15);
         set_limit(REG_BRANCH_COUNT_MAX, 15);
         set_limit(REG_BRANCH_NUMBER_MAX, 15);
         set_limit(REG_ALARM_COUNT_MAX, 255);
         set_limit(REG_CARD_COUNT_MAX, 15);
         set_limit(REG_SLOT_MAX, 63);
      end else if (setting == 2) begin
         set_limit(REG_CARRIER_MAX, 1);
         set_limit(REG_BRANCH_COUNT_MAX, 0);
         set_limit(REG_BRANCH_NUMBER_MAX, 0);
         set_limit(REG_ALARM_COUNT_MAX, 0);
         set_limit(REG_CARD_COUNT_MAX, 0);
         set_limit(REG_SLOT_MAX, 1);
      end else begin
         set_limit(REG_CARRIER_MAX, $urandom_range(15, 1));
         set_limit(REG_BRANCH_COUNT_MAX, $urandom_range(15, 0));
         set_limit(REG_BRANCH_NUMBER_MAX, $urandom_range(15, 0));
         set_limit(REG_ALARM_COUNT_MAX, $urandom_range(255, 0));
         set_limit(REG_CARD_COUNT_MAX, $urandom_range(15, 0));
         set_limit(REG_SLOT_MAX, $urandom_range(63, 1));
      end
      set_limit(REG_ALARM_CODE_MIN, code_lo);
      set_limit(REG_ALARM_CODE_MAX, code_hi);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Word driver: offer queued words, hold them under backpressure, and
   // feed each accepted word to the predictor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : word_driver
      word_item_t nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            advance_parser(req_ch.msg_word, req_ch.first_word);
            words_accepted++;
         end
         // Decide the next cycle's offer with a single assignment per signal
         if (tx_gap > 0) begin
            tx_gap--;
            req_ch.valid <= 1'b0;
         end else if (word_q.size() > 0) begin
            nxt = word_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.msg_word <= nxt.word;
            req_ch.first_word <= nxt.first;
            tx_gap = tx_idle_on ? idle_len() : 0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: check each accepted verdict against the oldest one owed,
   // and toggle ready with random stalls or a long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : verdict_monitor
      verdict_t owed;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (rsp_ch.status < 9)
               code_hits[rsp_ch.status]++;
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d value 0x%04h",
                                         rsp_ch.status, rsp_ch.bad_value));
            end else begin
               owed = verdict_q.pop_front();
               if (rsp_ch.status !== owed.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, owed.status));
               if (rsp_ch.bad_value !== owed.bad_value)
                  report_mismatch($sformatf("bad_value 0x%04h, expected 0x%04h",
                                            rsp_ch.bad_value, owed.bad_value));
            end
         end
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rx_gap = rx_stall_on ? idle_len() : 0;
         end
      end
   end

   // Hold off the result side for a long stretch mid-run so the block backs
   // up and stalls its input while words keep coming
   initial begin : long_hold
      rsp_hold = 1'b0;
      @(negedge clock);
      while (words_accepted < 250)
         @(negedge clock);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned setting;
      // Drive every input to a known value from time zero
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.msg_word = '0;
      req_ch.first_word = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_CARRIER_MAX;
      csr_wdata = '0;
      tx_idle_on = 1'b1;
      rx_stall_on = 1'b1;
      foreach (code_hits[i])
         code_hits[i] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset limits
      queue_word(1'b1, 16'd0);            // empty message: OK at once
      queue_word(1'b1, 16'hFFFF);         // carrier count far out of range
      queue_word(1'b0, 16'h5A5A);         // stray word while idle: ignore
      queue_word(1'b1, 16'd2);            // message that gets restarted
      queue_word(1'b0, 16'd3);
      // Full message at the limits, one of every section
      queue_word(1'b1, 16'd1);            // restarts the message above
      queue_word(1'b0, 16'd5);            // carrier number at its maximum
      queue_word(1'b0, 16'hFFFF);         // skipped words with all bits set and clear
      queue_word(1'b0, 16'h0000);
      queue_word(1'b0, 16'hA5C3);         // state word
      queue_word(1'b0, 16'd1);            // one branch
      queue_word(1'b0, 16'd7);            // branch number at its maximum
      queue_word(1'b0, 16'h0000);
      queue_word(1'b0, 16'hFFFF);
      queue_word(1'b0, 16'h3C5A);
      queue_word(1'b0, 16'd1);            // one alarm
      queue_word(1'b0, 16'd221);          // alarm code at its minimum
      queue_word(1'b0, 16'd1);            // one card
      queue_word(1'b0, 16'd56);           // slot at its maximum
      queue_word(1'b0, 16'h8001);         // word after a completed message: ignore

      random_phase(170);
      wait_idle();

      // Step through further limit settings, draining between them
      for (setting = 1; setting <= 5; setting++) begin
         configure(setting);
         // Run one setting without any idling, one with a busy sender only
         tx_idle_on <= (setting != 1 && setting != 4);
         rx_stall_on <= (setting != 1);
         bad_pct = $urandom_range(5, 1);
         random_phase(170);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

      $display("ran %0d words through 6 limit settings and checked %0d results",
               words_accepted, results_checked);
      $display("results: ok %0d, carrier cnt %0d, carrier no %0d, branch cnt %0d, %s",
               code_hits[0], code_hits[1], code_hits[2], code_hits[3],
               $sformatf("branch no %0d, alarm cnt %0d, alarm code %0d, card cnt %0d, slot %0d",
                         code_hits[4], code_hits[5], code_hits[6], code_hits[7],
                         code_hits[8]));
      if (mismatches == 0)
         $display("carrier_status_msg_checker_tb passed");
      else
         $display("carrier_status_msg_checker_tb failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/cmsc_pkg.sv
hdl/cmsc_if.sv
hdl/cmsc_cfg_regs.sv
hdl/cmsc_parser.sv
hdl/cmsc_rsp_reg.sv
hdl/carrier_status_msg_checker.sv
tb/carrier_status_msg_checker_tb.sv
